@@ rtl/rrrs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrrs_pkg
// shared constants and codes of the round-robin reclaim selector
// ----------------------------------------------------------------------------
package rrrs_pkg;

    localparam int MAX_PARTS = 16;
    localparam int MAX_SEGS  = 8;
    localparam int LEVELS    = 4;

    localparam int PART_W  = $clog2(MAX_PARTS);
    localparam int NPART_W = $clog2(MAX_PARTS + 1);
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int SEG_W   = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEGS + 1);
    localparam int CADDR_W = PART_W + LVL_W;
    localparam int SADDR_W = PART_W + LVL_W + SEG_W;

    localparam int CURSOR_W = 32;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    localparam logic [2:0] STAT_DISABLED = 3'd0;
    localparam logic [2:0] STAT_SLACK    = 3'd1;
    localparam logic [2:0] STAT_GC       = 3'd2;
    localparam logic [2:0] STAT_NOPARTS  = 3'd3;
    localparam logic [2:0] STAT_SCHED    = 3'd4;

    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_SLACK  = 2'd1;
    localparam logic [1:0] CFG_GAIN   = 2'd2;

endpackage

@@ rtl/round_robin_reclaim_selector_top.sv @@
// ----------------------------------------------------------------------------
// round_robin_reclaim_selector_top
// picks log segments to reclaim, round-robin over partitions and levels
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// input     in         i_valid / o_stall            action, segment, run data
// result    out        o_valid / i_stall            kind, status, decision
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// clear is done in idle, load in S_LD, a run that ends early in S_CHK or S_GC
// a scheduled run: S_MUL, the cursor remainder (bit-serial), then per level
// S_LS, visits through S_VA to S_VD (empty visits skip S_VC), S_LE and S_LN,
// all through the one count/segment memory port and the shared total adder,
// then a scan over the partitions and one result item after another
// reset is synchronous, active low; it empties all levels and the schedule
// o_stall is high during a load, and during a run until its last result is taken
// ----------------------------------------------------------------------------
module round_robin_reclaim_selector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_part_index,
    input  logic [1:0]  i_level_index,
    input  logic [62:0] i_seg_offset,
    input  logic [39:0] i_seg_size,
    input  logic [4:0]  i_part_total_count,
    input  logic [47:0] i_usage_total,
    input  logic [47:0] i_gc_reclaim,
    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [2:0]  o_status,
    output logic [3:0]  o_out_partition,
    output logic [62:0] o_cut_offset,
    output logic [48:0] o_part_reclaim,
    output logic [48:0] o_estimate_total,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import rrrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LD, S_CHK, S_MUL, S_GC, S_MOD, S_LS,
        S_VA, S_VB, S_VC, S_VD, S_LE, S_LN, S_SCAN, S_OUT
    } t_state;

    t_state r_state;

    // config registers
    logic [47:0] r_target;
    logic [39:0] r_slack;
    logic [15:0] r_gain;

    // schedule state
    logic [NPART_W-1:0]      r_parts;
    logic [CURSOR_W-1:0]     r_cursor;
    logic [2**CADDR_W-1:0]   r_cnt_vld;

    // per-partition run state
    logic [MAX_PARTS-1:0] r_decided;
    logic [62:0]          r_doff [MAX_PARTS];
    logic [48:0]          r_ptot [MAX_PARTS];
    logic [CNT_W-1:0]     r_lpos [MAX_PARTS];

    // run working registers
    logic [47:0]        r_usage;
    logic [47:0]        r_gc;
    logic [47:0]        r_excess;
    logic [55:0]        r_scaled;
    logic [55:0]        r_rem;
    logic [48:0]        r_est;
    logic [48:0]        r_total;
    logic               r_progress;
    logic [PART_W-1:0]  r_p;
    logic [PART_W-1:0]  r_first;
    logic [LVL_W-1:0]   r_lvl;

    // pending load
    logic [PART_W-1:0] r_ld_part;
    logic [LVL_W-1:0]  r_ld_lvl;
    logic [62:0]       r_ld_off;
    logic [39:0]       r_ld_size;

    // result register
    logic        r_o_valid;
    logic        r_o_kind;
    logic [2:0]  r_o_status;
    logic [3:0]  r_o_part;
    logic [62:0] r_o_cut;
    logic [48:0] r_o_recl;
    logic [48:0] r_o_est;
    logic        r_o_last;

    // memories
    logic [CNT_W-1:0] cnt_mem [2**CADDR_W];
    logic [62:0]      off_mem [2**SADDR_W];
    logic [39:0]      size_mem [2**SADDR_W];
    logic [CNT_W-1:0] r_cnt_rd;
    logic             r_cnt_rd_vld;
    logic [62:0]      r_off_rd;
    logic [39:0]      r_size_rd;

    logic [CADDR_W-1:0] w_cnt_raddr;
    logic [CADDR_W-1:0] w_ld_caddr;
    logic [SADDR_W-1:0] w_seg_raddr;
    logic [SADDR_W-1:0] w_seg_waddr;
    logic [CNT_W-1:0]   w_cnt;
    logic               w_ld_we;
    logic [47:0]        w_excess;
    logic [63:0]        w_prod;
    logic [PART_W-1:0]  n_p_next;
    logic               w_accept;
    logic               w_out_take;
    logic               w_mod_start;
    logic               w_mod_done;
    logic [PART_W-1:0]  w_mod_rem;
    logic [MAX_PARTS-1:0] w_above;

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign w_accept   = i_valid && !o_stall;
    assign w_out_take = r_o_valid && !i_stall;

    assign w_cnt_raddr = (r_state == S_IDLE) ? {i_part_index, i_level_index} : {r_p, r_lvl};
    assign w_ld_caddr  = {r_ld_part, r_ld_lvl};
    assign w_cnt       = r_cnt_rd_vld ? r_cnt_rd : '0;
    assign w_seg_raddr = {r_p, r_lvl, r_lpos[r_p][SEG_W-1:0]};
    assign w_seg_waddr = {r_ld_part, r_ld_lvl, w_cnt[SEG_W-1:0]};
    assign w_ld_we     = (r_state == S_LD) && (w_cnt < CNT_W'(MAX_SEGS));

    assign w_excess = (r_usage >= r_target) ? r_usage - r_target : '0;
    // 48 x 16 product, registered before use
    assign w_prod   = r_excess * r_gain;

    assign n_p_next = (({1'b0, r_p} + NPART_W'(1)) >= r_parts) ? '0 : r_p + PART_W'(1);

    // decided partitions above the scan index
    assign w_above = (r_decided >> r_p) >> 1;

    assign w_mod_start = (r_state == S_GC) && (r_scaled > {8'b0, r_gc})
                         && (r_parts != '0);

    rrrs_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_cursor),
        .i_divisor  (r_parts),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // ------------------------------------------------------------------
    // count and segment memories, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_cnt_rd <= cnt_mem[w_cnt_raddr];
        if (w_ld_we) begin
            cnt_mem[w_ld_caddr] <= w_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_off_rd  <= off_mem[w_seg_raddr];
        r_size_rd <= size_mem[w_seg_raddr];
        if (w_ld_we) begin
            off_mem[w_seg_waddr]  <= r_ld_off;
            size_mem[w_seg_waddr] <= r_ld_size;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_target     <= '0;
            r_slack      <= 40'd134217728;
            r_gain       <= 16'd256;
            r_parts      <= '0;
            r_cursor     <= '0;
            r_cnt_vld    <= '0;
            r_cnt_rd_vld <= 1'b0;
            r_decided    <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_cnt_rd_vld <= r_cnt_vld[w_cnt_raddr];

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TARGET: r_target <= i_cfg_data;
                    CFG_SLACK:  r_slack  <= i_cfg_data[39:0];
                    CFG_GAIN:   r_gain   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ld_part <= i_part_index;
                        r_ld_lvl  <= i_level_index;
                        r_ld_off  <= i_seg_offset;
                        r_ld_size <= i_seg_size;
                        r_usage   <= i_usage_total;
                        r_gc      <= i_gc_reclaim;
                        case (i_action)
                            ACT_CLEAR: begin
                                // saturate oversized partition count
                                r_parts   <= (i_part_total_count > NPART_W'(MAX_PARTS))
                                             ? NPART_W'(MAX_PARTS) : i_part_total_count;
                                r_cnt_vld <= '0;
                            end
                            ACT_LOAD: begin
                                if ({1'b0, i_part_index} < r_parts) begin
                                    r_state <= S_LD;
                                end
                            end
                            ACT_RUN: r_state <= S_CHK;
                            default: ;
                        endcase
                    end
                end
                S_LD: begin
                    if (w_ld_we) begin
                        r_cnt_vld[w_ld_caddr] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_CHK: begin
                    r_o_kind <= 1'b0;
                    r_o_part <= '0;
                    r_o_cut  <= '0;
                    r_o_recl <= '0;
                    r_o_est  <= '0;
                    r_o_last <= 1'b1;
                    if (r_target == '0) begin
                        r_o_status <= STAT_DISABLED;
                        r_o_valid  <= 1'b1;
                        r_state    <= S_OUT;
                    end else if (w_excess <= {8'b0, r_slack}) begin
                        r_o_status <= STAT_SLACK;
                        r_o_valid  <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_excess <= w_excess;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_scaled <= w_prod[63:8];
                    r_state  <= S_GC;
                end
                S_GC: begin
                    if (r_scaled <= {8'b0, r_gc}) begin
                        r_o_status <= STAT_GC;
                        r_o_valid  <= 1'b1;
                        r_state    <= S_OUT;
                    end else if (r_parts == '0) begin
                        r_o_status <= STAT_NOPARTS;
                        r_o_valid  <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        // fresh run scope
                        r_decided <= '0;
                        for (int i = 0; i < MAX_PARTS; i++) begin
                            r_doff[i] <= '0;
                            r_ptot[i] <= '0;
                        end
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_p     <= w_mod_rem;
                        r_lvl   <= '0;
                        r_rem   <= r_scaled;
                        r_est   <= '0;
                        r_state <= S_LS;
                    end
                end
                S_LS: begin
                    for (int i = 0; i < MAX_PARTS; i++) begin
                        r_lpos[i] <= '0;
                    end
                    r_total    <= '0;
                    r_progress <= 1'b0;
                    r_first    <= r_p;
                    r_state    <= S_VA;
                end
                S_VA: r_state <= S_VB;
                S_VB: begin
                    // segment read issued here when a candidate remains
                    r_state <= (r_lpos[r_p] < w_cnt) ? S_VC : S_VD;
                end
                S_VC: begin
                    r_decided[r_p] <= 1'b1;
                    r_doff[r_p]    <= r_off_rd;
                    r_ptot[r_p]    <= r_ptot[r_p] + 49'(r_size_rd);
                    r_total        <= r_total + 49'(r_size_rd);
                    r_progress     <= 1'b1;
                    r_lpos[r_p]    <= r_lpos[r_p] + CNT_W'(1);
                    r_state        <= S_VD;
                end
                S_VD: begin
                    r_cursor <= r_cursor + CURSOR_W'(1);
                    r_p      <= n_p_next;
                    if ({7'b0, r_total} > r_rem) begin
                        r_state <= S_LE;
                    end else if (n_p_next == r_first && !r_progress) begin
                        r_state <= S_LE;
                    end else begin
                        if (n_p_next == r_first) begin
                            r_progress <= 1'b0;
                        end
                        r_state <= S_VA;
                    end
                end
                S_LE: begin
                    r_est   <= r_est + r_total;
                    r_state <= S_LN;
                end
                S_LN: begin
                    if (r_lvl == LVL_W'(LEVELS - 1) || {7'b0, r_est} >= r_scaled) begin
                        r_o_kind   <= 1'b0;
                        r_o_status <= STAT_SCHED;
                        r_o_part   <= '0;
                        r_o_cut    <= '0;
                        r_o_recl   <= '0;
                        r_o_est    <= r_est;
                        r_o_last   <= ~|r_decided;
                        r_o_valid  <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_lvl   <= r_lvl + LVL_W'(1);
                        r_rem   <= r_scaled - {7'b0, r_est};
                        r_state <= S_LS;
                    end
                end
                S_SCAN: begin
                    if (r_decided[r_p]) begin
                        r_o_kind   <= 1'b1;
                        r_o_status <= STAT_SCHED;
                        r_o_part   <= 4'(r_p);
                        r_o_cut    <= r_doff[r_p];
                        r_o_recl   <= r_ptot[r_p];
                        r_o_est    <= '0;
                        r_o_last   <= ~|w_above;
                        r_o_valid  <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_p <= r_p + PART_W'(1);
                    end
                end
                S_OUT: begin
                    if (w_out_take) begin
                        r_o_valid <= 1'b0;
                        if (r_o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            // status goes first, then decisions in partition order
                            r_p     <= r_o_kind ? r_p + PART_W'(1) : '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_kind           = r_o_kind;
    assign o_status         = r_o_status;
    assign o_out_partition  = r_o_part;
    assign o_cut_offset     = r_o_cut;
    assign o_part_reclaim   = r_o_recl;
    assign o_estimate_total = r_o_est;
    assign o_last           = r_o_last;
    assign o_cfg_ready      = 1'b1;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && r_o_last) |=> (!r_o_valid && !o_stall))
        else $error("result after final item");

    a_decision_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind) |-> (r_o_status == STAT_SCHED && r_decided[r_o_part]))
        else $error("decision for unmarked partition");

    a_visit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VA) |-> ({1'b0, r_p} < r_parts))
        else $error("visit outside schedule");

    a_mark_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VC) |-> (r_lpos[r_p] < CNT_W'(MAX_SEGS)))
        else $error("walk past level end");

endmodule

@@ rtl/rrrs_mod_unit.sv @@
// ----------------------------------------------------------------------------
// rrrs_mod_unit
// bit-serial remainder of the visit cursor by the partition count
// ----------------------------------------------------------------------------
module rrrs_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rrrs_pkg::CURSOR_W-1:0] i_dividend,
    input  logic [rrrs_pkg::NPART_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [rrrs_pkg::PART_W-1:0]   o_rem
);
    import rrrs_pkg::*;

    localparam int STEP_W = $clog2(CURSOR_W + 1);

    logic [STEP_W-1:0]   r_step;
    logic                r_busy;
    logic                r_done;
    logic [CURSOR_W-1:0] r_dvd;
    logic [NPART_W-1:0]  r_div;
    logic [NPART_W-1:0]  r_rem;
    logic [NPART_W:0]    w_trial;
    logic [NPART_W:0]    w_next;

    // one quotient bit a cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[CURSOR_W-1]};
        w_next  = (w_trial >= {1'b0, r_div}) ? w_trial - {1'b0, r_div} : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_next[NPART_W-1:0];
                r_dvd <= {r_dvd[CURSOR_W-2:0], 1'b0};
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(CURSOR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[PART_W-1:0];

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without work");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done)
        else $error("busy and done together");

endmodule
